// ----- design/launch_speed_solver_wind_macros.svh -----
// Assertion macros for the launch speed solver.
`ifndef LAUNCH_SPEED_SOLVER_WIND_MACROS_SVH
`define LAUNCH_SPEED_SOLVER_WIND_MACROS_SVH
`ifndef SYNTHESIS
`define LSSW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define LSSW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define LSSW_ASSERT(label, prop, msg)
`define LSSW_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- design/lssw_pkg.sv -----
// Shared types and constants for the launch speed solver.
`timescale 1ns / 1ps
package lssw_pkg;
    localparam int ZW   = 34;   // CORDIC angle, Q30
    localparam int XW   = 33;   // CORDIC x/y, Q30
    localparam int CSW  = 17;   // sin/cos, Q14
    localparam int DXW  = 13;   // pixel offsets
    localparam int CFGW = 24;
    localparam int IDXW = 8;
    localparam int NW   = 38;
    localparam int DW   = 42;
    localparam int EW   = 56;
    localparam int GMW  = 24;
    localparam int GNW  = GMW + NW;
    localparam int NLO  = 19;
    localparam int ELO  = 28;
    localparam int PW   = 100;
    localparam int QW   = 98;
    localparam int RW   = 112;
    localparam int QUOW = 48;
    localparam int SPW  = 24;
    localparam int SAT_SHIFT = 13;
    localparam int TABLE_LEN = 24;

    localparam logic [IDXW-1:0] REG_GRAVITY = 8'd0;
    localparam logic [IDXW-1:0] REG_WIND    = 8'd1;

    localparam logic signed [ZW-1:0] HALF_PI30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI30      = 34'sd3373259426;
    localparam logic signed [XW-1:0] CORDIC_X0 = 33'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    typedef struct packed {
        logic valid;
        logic err;
    } lssw_tag_t;
endpackage

// ----- design/lssw_cordic.sv -----
// Pipelined rotation CORDIC giving Q14 sine and cosine, one iteration per stage.
`timescale 1ns / 1ps
module lssw_cordic #(
    parameter int ITER   = 16,
    parameter int SIDE_W = 26
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [15:0]           angle,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic signed [lssw_pkg::CSW-1:0] cos_q14,
    output logic signed [lssw_pkg::CSW-1:0] sin_q14,
    output logic [SIDE_W-1:0]            side_out
);
    import lssw_pkg::*;

    logic              v_reg    [ITER+1];
    logic signed [ZW-1:0] z_reg [ITER+1];
    logic signed [XW-1:0] x_reg [ITER+1];
    logic signed [XW-1:0] y_reg [ITER+1];
    logic              neg_reg  [ITER+1];
    logic [SIDE_W-1:0] side_reg [ITER+1];

    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] z0_next;
    logic                 neg0_next;

    // half-turn fold keeps the angle inside the CORDIC range
    always_comb begin
        z_in = {{(ZW-33){angle[15]}}, angle, 17'b0};
        z0_next = z_in;
        neg0_next = 1'b0;
        if (z_in > HALF_PI30) begin
            z0_next = z_in - PI30;
            neg0_next = 1'b1;
        end else if (z_in < -HALF_PI30) begin
            z0_next = z_in + PI30;
            neg0_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            z_reg[0]    <= z0_next;
            x_reg[0]    <= CORDIC_X0;
            y_reg[0]    <= '0;
            neg_reg[0]  <= neg0_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_iter
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                if (!z_reg[i][ZW-1]) begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_Q30[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_Q30[i];
                end
                neg_reg[i+1]  <= neg_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    logic signed [XW:0]    xr_sum;
    logic signed [XW:0]    yr_sum;
    logic signed [CSW-1:0] xr;
    logic signed [CSW-1:0] yr;
    logic                  v_out_reg;
    logic signed [CSW-1:0] c_reg;
    logic signed [CSW-1:0] s_reg;
    logic [SIDE_W-1:0]     side_out_reg;

    // round half up to Q14
    always_comb begin
        xr_sum = (XW+1)'(x_reg[ITER]) + (XW+1)'(32768);
        yr_sum = (XW+1)'(y_reg[ITER]) + (XW+1)'(32768);
        xr = CSW'(xr_sum >>> 16);
        yr = CSW'(yr_sum >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out_reg <= 1'b0;
        end else if (en) begin
            v_out_reg <= v_reg[ITER];
        end
        if (en) begin
            c_reg        <= neg_reg[ITER] ? -xr : xr;
            s_reg        <= neg_reg[ITER] ? -yr : yr;
            side_out_reg <= side_reg[ITER];
        end
    end

    assign out_valid = v_out_reg;
    assign cos_q14   = c_reg;
    assign sin_q14   = s_reg;
    assign side_out  = side_out_reg;
endmodule

// ----- design/lssw_root.sv -----
// Pipelined long division and integer square root, one bit per stage.
`timescale 1ns / 1ps
module lssw_root (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  lssw_pkg::lssw_tag_t         in_tag,
    input  logic [lssw_pkg::PW-1:0]     p,
    input  logic [lssw_pkg::QW-1:0]     q,
    output logic                        out_valid,
    output logic [lssw_pkg::SPW-1:0]    speed,
    output logic                        speed_ok
);
    import lssw_pkg::*;

    localparam int DIV_N  = QUOW;
    localparam int SQ_N   = QUOW / 2;
    localparam int PHASE1 = SAT_SHIFT;

    lssw_tag_t         dtag_reg [DIV_N+1];
    logic              dsat_reg [DIV_N+1];
    logic [RW-1:0]     r_reg    [DIV_N+1];
    logic [QW-1:0]     q_reg    [DIV_N+1];
    logic [QUOW-1:0]   quo_reg  [DIV_N+1];

    logic sat_next;
    assign sat_next = (RW'(p)) >= (RW'(q) << SAT_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dtag_reg[0].valid <= 1'b0;
        end else if (en) begin
            dtag_reg[0].valid <= in_tag.valid;
        end
        if (en) begin
            dtag_reg[0].err <= in_tag.err;
            dsat_reg[0]     <= sat_next;
            r_reg[0]        <= RW'(p);
            q_reg[0]        <= q;
            quo_reg[0]      <= '0;
        end
    end

    // first steps subtract shifted divisors, the rest shift the remainder
    for (genvar j = 0; j < DIV_N; j++) begin : g_div
        logic [RW-1:0] rr;
        logic [RW-1:0] cmp;
        logic          take;
        if (j < PHASE1) begin : g_p1
            assign rr  = r_reg[j];
            assign cmp = RW'(q_reg[j]) << (PHASE1 - 1 - j);
        end else begin : g_p2
            assign rr  = r_reg[j] << 1;
            assign cmp = RW'(q_reg[j]);
        end
        assign take = rr >= cmp;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dtag_reg[j+1].valid <= 1'b0;
            end else if (en) begin
                dtag_reg[j+1].valid <= dtag_reg[j].valid;
            end
            if (en) begin
                dtag_reg[j+1].err <= dtag_reg[j].err;
                dsat_reg[j+1]     <= dsat_reg[j];
                q_reg[j+1]        <= q_reg[j];
                r_reg[j+1]        <= take ? rr - cmp : rr;
                quo_reg[j+1]      <= quo_reg[j] | (QUOW'(take) << (DIV_N - 1 - j));
            end
        end
    end

    lssw_tag_t         stag_reg [SQ_N+1];
    logic              ssat_reg [SQ_N+1];
    logic [QUOW-1:0]   v_reg    [SQ_N+1];
    logic [QUOW-1:0]   res_reg  [SQ_N+1];

    always_comb begin
        stag_reg[0] = dtag_reg[DIV_N];
        ssat_reg[0] = dsat_reg[DIV_N];
        v_reg[0]    = quo_reg[DIV_N];
        res_reg[0]  = '0;
    end

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam logic [QUOW-1:0] BIT = QUOW'(1) << (QUOW - 2 - 2 * j);
        logic [QUOW-1:0] trial;
        assign trial = res_reg[j] + BIT;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stag_reg[j+1].valid <= 1'b0;
            end else if (en) begin
                stag_reg[j+1].valid <= stag_reg[j].valid;
            end
            if (en) begin
                stag_reg[j+1].err <= stag_reg[j].err;
                ssat_reg[j+1]     <= ssat_reg[j];
                if (v_reg[j] >= trial) begin
                    v_reg[j+1]   <= v_reg[j] - trial;
                    res_reg[j+1] <= (res_reg[j] >> 1) + BIT;
                end else begin
                    v_reg[j+1]   <= v_reg[j];
                    res_reg[j+1] <= res_reg[j] >> 1;
                end
            end
        end
    end

    logic            out_valid_reg;
    logic [SPW-1:0]  speed_reg;
    logic            ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= stag_reg[SQ_N].valid;
        end
        if (en) begin
            ok_reg <= !stag_reg[SQ_N].err;
            if (stag_reg[SQ_N].err) begin
                speed_reg <= '0;
            end else if (ssat_reg[SQ_N]) begin
                speed_reg <= '1;
            end else begin
                speed_reg <= SPW'(res_reg[SQ_N]);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign speed     = speed_reg;
    assign speed_ok  = ok_reg;
endmodule

// ----- design/launch_speed_solver_wind.sv -----
// Launch speed solver under gravity and wind: top level.
`timescale 1ns / 1ps
// Takes one solve per clock and returns the launch speed after CORDIC_ITERATIONS
// + 2 stages of sine/cosine, four stages of products, one overflow check, 48
// divider stages (one quotient bit each), 24 square root stages and the output
// register. The whole pipeline advances when the output register is empty or
// being taken, so a stall at m_ready holds every stage. speed_valid is low
// with speed 0 for a zero divisor or a radicand that is zero or negative; a
// quotient of 2^48 or more saturates the speed to all ones.
module launch_speed_solver_wind #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [7:0]              cfg_index,
    input  logic [23:0]             cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [11:0]             s_launcher_x,
    input  logic [11:0]             s_launcher_y,
    input  logic [11:0]             s_target_x,
    input  logic [11:0]             s_target_y,
    input  logic signed [15:0]      s_launch_angle,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [23:0]             m_launch_speed,
    output logic                    m_speed_valid
);
    import lssw_pkg::*;
    `include "launch_speed_solver_wind_macros.svh"

    logic signed [CFGW-1:0] grav_reg;
    logic signed [CFGW-1:0] wind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= 24'sd2560;
            wind_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_GRAVITY) begin
                grav_reg <= cfg_wdata;
            end else if (cfg_index == REG_WIND) begin
                wind_reg <= cfg_wdata;
            end
        end
    end

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [DXW-1:0] dx_in;
    logic signed [DXW-1:0] dy_in;
    assign dx_in = DXW'(s_target_x) - DXW'(s_launcher_x);
    assign dy_in = DXW'(s_target_y) - DXW'(s_launcher_y);

    logic                  cv;
    logic signed [CSW-1:0] c_q14;
    logic signed [CSW-1:0] s_q14;
    logic [2*DXW-1:0]      side;

    lssw_cordic #(
        .ITER   (CORDIC_ITERATIONS),
        .SIDE_W (2 * DXW)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .angle    (s_launch_angle),
        .side_in  ({dx_in, dy_in}),
        .out_valid(cv),
        .cos_q14  (c_q14),
        .sin_q14  (s_q14),
        .side_out (side)
    );

    logic signed [DXW-1:0] dx_c;
    logic signed [DXW-1:0] dy_c;
    assign dx_c = side[2*DXW-1:DXW];
    assign dy_c = side[DXW-1:0];

    // stage B: numerator and denominator
    logic                  b_v_reg;
    logic signed [NW-1:0]  b_n_reg;
    logic signed [DW-1:0]  b_d_reg;
    logic signed [CSW-1:0] b_s_reg;
    logic signed [DXW-1:0] b_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg <= cv;
        end
        if (en) begin
            b_n_reg  <= grav_reg * dx_c - wind_reg * dy_c;
            b_d_reg  <= grav_reg * c_q14 + wind_reg * s_q14;
            b_s_reg  <= s_q14;
            b_dy_reg <= dy_c;
        end
    end

    // stage C: E and |G|*|N|
    logic [GMW-1:0] g_mag;
    logic [NW-1:0]  n_mag;
    logic [DW-1:0]  d_mag;
    assign g_mag = grav_reg[CFGW-1] ? GMW'(-grav_reg) : GMW'(grav_reg);
    assign n_mag = b_n_reg[NW-1] ? NW'(-b_n_reg) : NW'(b_n_reg);
    assign d_mag = b_d_reg[DW-1] ? DW'(-b_d_reg) : DW'(b_d_reg);

    logic                 c_v_reg;
    logic signed [EW-1:0] c_e_reg;
    logic [GNW-1:0]       c_gn_reg;
    logic [NW-1:0]        c_nmag_reg;
    logic [DW-1:0]        c_dmag_reg;
    logic                 c_zero_reg;
    logic                 c_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en) begin
            c_v_reg <= b_v_reg;
        end
        if (en) begin
            c_e_reg    <= b_n_reg * b_s_reg + b_dy_reg * b_d_reg;
            c_gn_reg   <= GNW'(g_mag) * GNW'(n_mag);
            c_nmag_reg <= n_mag;
            c_dmag_reg <= d_mag;
            c_zero_reg <= (b_d_reg == '0) || (b_n_reg == '0) || (grav_reg == '0);
            c_neg_reg  <= grav_reg[CFGW-1] ^ b_d_reg[DW-1];
        end
    end

    // stage D: partial products
    localparam int PPW = GNW + NLO;
    localparam int QPW = DW + ELO;

    logic [EW-1:0] e_mag;
    assign e_mag = c_e_reg[EW-1] ? EW'(-c_e_reg) : EW'(c_e_reg);

    lssw_tag_t      d_tag_reg;
    logic [PPW-1:0] d_plo_reg;
    logic [PPW-1:0] d_phi_reg;
    logic [QPW-1:0] d_qlo_reg;
    logic [QPW-1:0] d_qhi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_tag_reg.valid <= 1'b0;
        end else if (en) begin
            d_tag_reg.valid <= c_v_reg;
        end
        if (en) begin
            d_tag_reg.err <= c_zero_reg || (c_e_reg == '0) || (c_neg_reg ^ c_e_reg[EW-1]);
            d_plo_reg <= PPW'(c_gn_reg) * PPW'(c_nmag_reg[NLO-1:0]);
            d_phi_reg <= PPW'(c_gn_reg) * PPW'(c_nmag_reg[NW-1:NLO]);
            d_qlo_reg <= QPW'(c_dmag_reg) * QPW'(e_mag[ELO-1:0]);
            d_qhi_reg <= QPW'(c_dmag_reg) * QPW'(e_mag[EW-1:ELO]);
        end
    end

    // stage E: recombine
    lssw_tag_t     e_tag_reg;
    logic [PW-1:0] e_p_reg;
    logic [QW-1:0] e_q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_tag_reg.valid <= 1'b0;
        end else if (en) begin
            e_tag_reg.valid <= d_tag_reg.valid;
        end
        if (en) begin
            e_tag_reg.err <= d_tag_reg.err;
            e_p_reg <= PW'(d_plo_reg) + (PW'(d_phi_reg) << NLO);
            e_q_reg <= QW'(d_qlo_reg) + (QW'(d_qhi_reg) << ELO);
        end
    end

    lssw_root u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_tag   (e_tag_reg),
        .p        (e_p_reg),
        .q        (e_q_reg),
        .out_valid(m_valid),
        .speed    (m_launch_speed),
        .speed_ok (m_speed_valid)
    );

    `LSSW_ASSERT(a_fail_zero, m_valid && !m_speed_valid |-> m_launch_speed == '0, "failed beat carries nonzero speed")
    `LSSW_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")
    `LSSW_ASSERT(a_zero_grav, $past(en) && $past(e_tag_reg.valid) && $past(grav_reg) == '0 |-> $past(e_tag_reg.err), "zero gravity not flagged")
endmodule

// ----- tb/launch_speed_solver_wind_checker.sv -----
// Checker for the launch speed solver: predicts each result and compares it.
`timescale 1ns / 1ps
module launch_speed_solver_wind_checker #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_index,
    input  logic [23:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [11:0]        s_launcher_x,
    input  logic [11:0]        s_launcher_y,
    input  logic [11:0]        s_target_x,
    input  logic [11:0]        s_target_y,
    input  logic signed [15:0] s_launch_angle,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [23:0]        m_launch_speed,
    input  logic               m_speed_valid,
    output int                 errors,
    output int                 pending
);
    import lssw_pkg::*;

    typedef struct {
        logic [23:0] speed;
        logic        ok;
    } speed_t;

    speed_t      speed_q[$];
    logic signed [23:0] gravity, wind;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 46;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic speed_t solve_speed(input logic [11:0] lx, ly, tx, ty,
                                           input logic signed [15:0] ang);
        longint z, x, y, xs, ys, dx, dy, g, w, sn, cs, n, d, e;
        logic   flip;
        int     negs;
        logic [159:0] p, q, quo;
        speed_t r;
        g = gravity;
        w = wind;
        dx = longint'(tx) - longint'(lx);
        dy = longint'(ty) - longint'(ly);
        z = longint'(ang) * 131072;
        x = CORDIC_X0;
        y = 0;
        flip = 0;
        // fold into +-pi/2, negate sin/cos at the end
        if (z > longint'(HALF_PI30)) begin
            z = z - longint'(PI30);
            flip = 1;
        end else if (z < -longint'(HALF_PI30)) begin
            z = z + longint'(PI30);
            flip = 1;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(ATAN_Q30[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(ATAN_Q30[i]);
            end
        end
        cs = (x + 32768) >>> 16;
        sn = (y + 32768) >>> 16;
        if (flip) begin
            cs = -cs;
            sn = -sn;
        end
        n = g * dx - w * dy;
        d = g * cs + w * sn;
        e = n * sn + dy * d;
        r.speed = '0;
        r.ok = 0;
        if (d == 0 || e == 0 || g == 0 || n == 0) return r;
        negs = (g < 0) + (d < 0) + (e < 0);
        if (negs % 2 == 1) return r;
        r.ok = 1;
        p = 160'(magnitude(g)) * 160'(magnitude(n)) * 160'(magnitude(n));
        q = 160'(magnitude(d)) * 160'(magnitude(e));
        if (p >= (q << 13)) begin
            r.speed = 24'hFFFFFF;
            return r;
        end
        quo = (p << 35) / q;
        r.speed = 24'(int_sqrt(quo[63:0]));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got, want);
        $display("tb: %s mismatch at %0t: got %h expected %h", what, $realtime, got, want);
        errors++;
    endtask

    assign pending = speed_q.size();

    always @(posedge aclk) begin
        speed_t want;
        if (!aresetn) begin
            gravity <= 24'sd2560;
            wind    <= 24'sd0;
        end else begin
            if (s_valid && s_ready)
                speed_q.push_back(solve_speed(s_launcher_x, s_launcher_y, s_target_x,
                                              s_target_y, s_launch_angle));
            if (m_valid && m_ready) begin
                if (speed_q.size() == 0) begin
                    $display("tb: unexpected result beat at %0t", $realtime);
                    errors++;
                end else begin
                    want = speed_q.pop_front();
                    if (m_launch_speed !== want.speed)
                        report_mismatch("launch_speed", m_launch_speed, want.speed);
                    if (m_speed_valid !== want.ok)
                        report_mismatch("speed_valid", 24'(m_speed_valid), 24'(want.ok));
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_GRAVITY) gravity <= cfg_wdata;
                else if (cfg_index == REG_WIND) wind <= cfg_wdata;
            end
        end
    end
endmodule

// ----- tb/launch_speed_solver_wind_tb.sv -----
// Testbench top for the launch speed solver: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module launch_speed_solver_wind_tb;
    import lssw_pkg::*;

    localparam int LIMIT = 300000;

    logic               aclk, aresetn;
    logic               cfg_wr_en;
    logic [7:0]         cfg_index;
    logic [23:0]        cfg_wdata;
    logic               s_valid, s_ready;
    logic [11:0]        s_launcher_x, s_launcher_y, s_target_x, s_target_y;
    logic signed [15:0] s_launch_angle;
    logic               m_valid, m_ready;
    logic [23:0]        m_launch_speed;
    logic               m_speed_valid;
    int                 errors, pending, cycles, stall_left;
    logic               no_idle;

    launch_speed_solver_wind DUT (.*);

    launch_speed_solver_wind_checker checker_i (.*);

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_ready <= 1'b1;
        end else if (m_valid && m_ready && !no_idle) begin
            if ($urandom_range(0, 1)) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(1, 4);
            end else begin
                stall_left <= 0;
            end
        end
    end

    task automatic send_beat(input logic [11:0] lx, ly, tx, ty, input logic [15:0] ang);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_launcher_x   <= lx;
        s_launcher_y   <= ly;
        s_target_x     <= tx;
        s_target_y     <= ty;
        s_launch_angle <= ang;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drain, let the pipe settle, then write one register
    task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_beat();
        logic [11:0] lx, ly;
        logic [15:0] ang;
        lx = 12'($urandom);
        ly = 12'($urandom);
        ang = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(0, 51472) - 25736);
        if ($urandom_range(0, 3) == 0)
            send_beat(lx, ly, lx + 12'($urandom_range(0, 15)),
                      ly - 12'($urandom_range(0, 15)), ang);
        else
            send_beat(lx, ly, 12'($urandom), 12'($urandom), ang);
    endtask

    initial begin
        logic [23:0] gsel[4];
        logic [23:0] wsel[4];
        no_idle        = 0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_launcher_x   = '0;
        s_launcher_y   = '0;
        s_target_x     = '0;
        s_target_y     = '0;
        s_launch_angle = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset gravity, no wind
        send_beat(0, 0, 0, 0, 0);                        // zero offset
        send_beat(0, 0, 4095, 4095, 16'sd25736);
        send_beat(4095, 4095, 0, 0, -16'sd25736);
        send_beat(0, 4095, 4095, 0, 16'sd6434);
        send_beat(100, 2000, 900, 2000, 16'sd0);
        send_beat(100, 2000, 900, 2000, 16'sd12868);     // straight up
        send_beat(100, 2000, 900, 1000, 16'sd32767);     // beyond pi
        send_beat(900, 2000, 100, 1000, -16'sd32768);
        send_beat(0, 0, 1, 0, 16'sd6434);                // tiny hop
        send_beat(0, 0, 4095, 0, 16'sd1);                // near flat: very fast
        send_beat(0, 4095, 4095, 4095, 16'sd3217);
        write_reg(REG_WIND, 24'h7FFFFF);
        send_beat(10, 10, 4000, 4000, 16'sd6434);
        send_beat(4000, 10, 10, 4000, -16'sd20000);
        write_reg(REG_GRAVITY, 24'h800000);
        send_beat(10, 4000, 4000, 10, 16'sd25736);
        send_beat(2000, 2000, 2000, 2000, 16'sd100);
        write_reg(REG_GRAVITY, 24'h000000);              // no gravity: no solution
        write_reg(REG_WIND, 24'h000000);
        send_beat(0, 0, 500, 500, 16'sd0);               // zero divisor
        send_beat(0, 0, 500, 500, 16'sd6434);

        gsel = '{24'h7FFFFF, 24'h800000, 24'h000A00, 24'h000001};
        wsel = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_GRAVITY, ph < 4 ? gsel[ph] : 24'($urandom));
            write_reg(REG_WIND, ph < 4 ? wsel[ph] : 24'($urandom_range(0, 8191) - 4096));
            no_idle = (ph == 2);
            for (int i = 0; i < 115; i++) random_beat();
        end
        s_valid <= 1'b0;
        no_idle = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+design
design/lssw_pkg.sv
design/lssw_cordic.sv
design/lssw_root.sv
design/launch_speed_solver_wind.sv
tb/launch_speed_solver_wind_checker.sv
tb/launch_speed_solver_wind_tb.sv
